// ===== hdl/fifo_ready_queue_with_removal_core_macros.svh =====
// Assertion macros used by the checker file of the ready queue.
`ifndef FIFO_READY_QUEUE_WITH_REMOVAL_CORE_MACROS_SVH
`define FIFO_READY_QUEUE_WITH_REMOVAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FRQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ready queue assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FRQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ready queue assertion failed");

`endif

// ===== hdl/frq_pkg.sv =====
`default_nettype none
package frq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int ID_WIDTH      = 8;
   localparam int PTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_WIDTH     = 2;
   localparam int ID_PORT_WIDTH = 8;
   localparam int OCC_WIDTH     = 5;

   localparam logic [REQ_WIDTH-1:0] REQ_APPEND = 2'd0;
   localparam logic [REQ_WIDTH-1:0] REQ_TAKE   = 2'd1;
   localparam logic [REQ_WIDTH-1:0] REQ_REMOVE = 2'd2;

   typedef struct packed {
      logic                 en;
      logic [PTR_WIDTH-1:0] addr;
      logic [ID_WIDTH-1:0]  data;
   } wr_port_type;

   // Position of the entry that lies off places behind base, wrapped once.
   function automatic logic [PTR_WIDTH-1:0] slot_of(input logic [PTR_WIDTH-1:0] base,
                                                    input logic [CNT_WIDTH-1:0] off);
      logic [PTR_WIDTH:0] sum;
      sum = (PTR_WIDTH+1)'(base) + (PTR_WIDTH+1)'(off);
      if (sum >= (PTR_WIDTH+1)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_WIDTH+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/fifo_ready_queue_with_removal_core.sv =====
`default_nettype none
// Ready queue of thread identifiers held in a circular buffer in one RAM.
// A request is accepted at a clock edge where start is high and busy is low;
// req_type selects append at the tail, take from the head, or remove the
// first entry equal to req_thread_id, closing the gap behind it.
// Each request yields exactly one result, shown for one cycle with rsp_valid
// high; the receiver cannot stall, so results are never held back.
// An append, any request on an empty queue and the unused request code strobe
// their result in the cycle after acceptance; a take first passes through the
// take state, since the head is read from the RAM; a remove walks every entry
// in the walk state, reading one entry per cycle through the single RAM read
// port and writing each entry behind a match back one place earlier.
// busy is high only while a take or a walk is running; a new request may be
// accepted in the cycle the previous result is strobed.
// Synchronous reset empties the queue; the RAM contents are not cleared.
module fifo_ready_queue_with_removal_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [frq_pkg::REQ_WIDTH-1:0]     req_type,
   input  wire logic [frq_pkg::ID_PORT_WIDTH-1:0] req_thread_id,
   output logic                                   rsp_valid,
   output logic                                   rsp_dispatch_valid,
   output logic      [frq_pkg::ID_PORT_WIDTH-1:0] rsp_dispatch_id,
   output logic                                   rsp_removed,
   output logic                                   rsp_overflow,
   output logic      [frq_pkg::OCC_WIDTH-1:0]     rsp_occupancy
);
   import frq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TAKE = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [PTR_WIDTH-1:0]     head_ff, head_in;
   logic [CNT_WIDTH-1:0]     count_ff, count_in;
   logic [CNT_WIDTH-1:0]     idx_ff, idx_in;
   logic                     found_ff, found_in;
   logic [ID_WIDTH-1:0]      id_ff, id_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     dvalid_ff, dvalid_in;
   logic [ID_PORT_WIDTH-1:0] did_ff, did_in;
   logic                     removed_ff, removed_in;
   logic                     overflow_ff, overflow_in;
   logic [OCC_WIDTH-1:0]     occ_ff, occ_in;

   logic                     accept;
   logic [ID_WIDTH-1:0]      id_req;
   logic                     match;
   wr_port_type              wr;
   logic [PTR_WIDTH-1:0]     rd_addr;
   logic [ID_WIDTH-1:0]      rd_data;

   frq_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;
   assign id_req = ID_WIDTH'(req_thread_id);
   assign match  = (rd_data == id_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      id_in        = id_ff;
      rsp_valid_in = 1'b0;
      dvalid_in    = 1'b0;
      did_in       = '0;
      removed_in   = 1'b0;
      overflow_in  = 1'b0;
      wr           = '0;
      rd_addr      = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_WIDTH'(QUEUE_DEPTH)) begin
                        overflow_in = 1'b1;
                     end else begin
                        wr.en    = 1'b1;
                        wr.addr  = slot_of(head_ff, count_ff);
                        wr.data  = id_req;
                        count_in = count_ff + CNT_WIDTH'(1);
                     end
                  end
                  REQ_TAKE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_TAKE;
                     end
                  end
                  REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_WALK;
                        idx_in   = '0;
                        found_in = 1'b0;
                        id_in    = id_req;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_TAKE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            dvalid_in    = 1'b1;
            did_in       = ID_PORT_WIDTH'(rd_data);
            head_in      = slot_of(head_ff, CNT_WIDTH'(1));
            count_in     = count_ff - CNT_WIDTH'(1);
         end
         ST_WALK: begin
            // rd_data holds entry idx_ff; the next entry is read meanwhile.
            rd_addr = slot_of(head_ff, idx_ff + CNT_WIDTH'(1));
            if (found_ff) begin
               wr.en   = 1'b1;
               wr.addr = slot_of(head_ff, idx_ff - CNT_WIDTH'(1));
               wr.data = rd_data;
            end else if (match) begin
               found_in = 1'b1;
            end
            if (idx_ff == count_ff - CNT_WIDTH'(1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               removed_in   = found_ff | match;
               if (found_ff | match) begin
                  count_in = count_ff - CNT_WIDTH'(1);
               end
            end else begin
               idx_in = idx_ff + CNT_WIDTH'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      occ_in = OCC_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      id_ff       <= id_in;
      dvalid_ff   <= dvalid_in;
      did_ff      <= did_in;
      removed_ff  <= removed_in;
      overflow_ff <= overflow_in;
      occ_ff      <= occ_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dispatch_valid = dvalid_ff;
   assign rsp_dispatch_id    = did_ff;
   assign rsp_removed        = removed_ff;
   assign rsp_overflow       = overflow_ff;
   assign rsp_occupancy      = occ_ff;

endmodule
`default_nettype wire

// ===== hdl/frq_ram.sv =====
`default_nettype none
module frq_ram (
   input  wire logic                         clock,
   input  wire frq_pkg::wr_port_type         wr,
   input  wire logic [frq_pkg::PTR_WIDTH-1:0] rd_addr,
   output logic      [frq_pkg::ID_WIDTH-1:0]  rd_data
);
   import frq_pkg::*;

   logic [ID_WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0] rd_data_ff;

   // A read of the entry written in the same cycle returns the old contents.
   // The controller never uses the data from such a read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/frq_checker.sv =====
`default_nettype none
`include "fifo_ready_queue_with_removal_core_macros.svh"
module frq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic [frq_pkg::REQ_WIDTH-1:0]     req_type,
   input wire logic [frq_pkg::ID_PORT_WIDTH-1:0] req_thread_id,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_dispatch_valid,
   input wire logic [frq_pkg::ID_PORT_WIDTH-1:0] rsp_dispatch_id,
   input wire logic                              rsp_removed,
   input wire logic                              rsp_overflow,
   input wire logic [frq_pkg::OCC_WIDTH-1:0]     rsp_occupancy
);
   import frq_pkg::*;

   // Every accepted transaction either finishes next cycle or keeps busy high.
   `FRQ_ASSERT_NXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)
   // An append never needs the RAM read path, so its result follows at once.
   `FRQ_ASSERT_NXT(a_append_one_cycle, clock, reset,
                   start && !busy && req_type == REQ_APPEND, rsp_valid && !busy)
   `FRQ_ASSERT_IMP(a_flags_exclusive, clock, reset, rsp_valid,
                   $onehot0({rsp_dispatch_valid, rsp_removed, rsp_overflow}))
   `FRQ_ASSERT_IMP(a_overflow_full, clock, reset, rsp_valid && rsp_overflow,
                   rsp_occupancy == OCC_WIDTH'(QUEUE_DEPTH))
   `FRQ_ASSERT_IMP(a_no_dispatch_zero_id, clock, reset, rsp_valid && !rsp_dispatch_valid,
                   rsp_dispatch_id == '0)

endmodule

bind fifo_ready_queue_with_removal_core frq_checker u_frq_checker (.*);
`default_nettype wire
